[hw/rtl/bfi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfi_pkg - shared types and codes for the tape language interpreter
// Transaction structs, command codes, result kinds and sequencer states.
// ----------------------------------------------------------------------------
package bfi_pkg;

   // Request actions
   localparam logic [1:0] ACT_LOAD   = 2'd0;
   localparam logic [1:0] ACT_FINISH = 2'd1;
   localparam logic [1:0] ACT_RUN    = 2'd2;

   // Program characters
   localparam logic [7:0] CH_RIGHT   = 8'h3E; // '>'
   localparam logic [7:0] CH_LEFT    = 8'h3C; // '<'
   localparam logic [7:0] CH_INC     = 8'h2B; // '+'
   localparam logic [7:0] CH_DEC     = 8'h2D; // '-'
   localparam logic [7:0] CH_OUT     = 8'h2E; // '.'
   localparam logic [7:0] CH_IN      = 8'h2C; // ','
   localparam logic [7:0] CH_OPEN    = 8'h5B; // '['
   localparam logic [7:0] CH_CLOSE   = 8'h5D; // ']'
   localparam logic [7:0] CH_NEWLINE = 8'h0A;

   // Result kinds
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_BYTE    = 3'd1;
   localparam logic [2:0] KIND_END     = 3'd2;
   localparam logic [2:0] KIND_FAULT   = 3'd3;
   localparam logic [2:0] KIND_INVALID = 3'd4;
   localparam logic [2:0] KIND_ACCEPT  = 3'd5;

   typedef enum logic [3:0] {
      OP_NONE  = 4'd0,
      OP_RIGHT = 4'd1,
      OP_LEFT  = 4'd2,
      OP_INC   = 4'd3,
      OP_DEC   = 4'd4,
      OP_OUT   = 4'd5,
      OP_IN    = 4'd6,
      OP_OPEN  = 4'd7,
      OP_CLOSE = 4'd8
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_PAIR,
      S_CLEAR,
      S_EXEC,
      S_WANT,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] value;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] out_byte;
      logic       wants_input;
   } rsp_type;

   function automatic op_type decode_op(input logic [7:0] ch);
      op_type op;
      unique case (ch)
         CH_RIGHT: op = OP_RIGHT;
         CH_LEFT:  op = OP_LEFT;
         CH_INC:   op = OP_INC;
         CH_DEC:   op = OP_DEC;
         CH_OUT:   op = OP_OUT;
         CH_IN:    op = OP_IN;
         CH_OPEN:  op = OP_OPEN;
         CH_CLOSE: op = OP_CLOSE;
         default:  op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

[hw/rtl/brainfuck_interpreter_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brainfuck_interpreter_core - eight-command tape language interpreter
// Loads a program byte by byte, pairs brackets on the fly, checks it and then
// runs one instruction per execute transaction over a byte tape.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Ports                          Payload
//  -------  ---  -----------------------------  ------------------------------
//  req      in   req_valid, req_ready, req_data  action[1:0], value[7:0]
//  rsp      out  rsp_valid, rsp_ready, rsp_data  kind[2:0], out_byte, wants_input
//
//  Every request transaction yields exactly one response transaction.
//  Load: the load state, then a pair state for the second jump table write
//  when a ']' closes a pair; an accepted newline adds the tape sweep.
//  Execute: program store and tape read, execute and write back, fetch of
//  the next command for wants_input, response; a pointer fault skips the fetch.
//  Ignored, rejected finish and run-off-the-end transactions: response only.
//  Accepted finish: the tape is swept to zero one cell per cycle through its
//  single write port.
//  Reset clears the control state only; the stores are undefined until
//  written. req_ready is low while a transaction is in progress, and a
//  stalled rsp holds the sequencer in its response state.
// ----------------------------------------------------------------------------
module brainfuck_interpreter_core #(
   parameter int TAPE_SIZE  = 1024,
   parameter int PROG_DEPTH = 4096,
   parameter int NEST_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bfi_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bfi_pkg::rsp_type  rsp_data
);

   // Widths: PW addresses the program, LW counts up to PROG_DEPTH inclusive.
   localparam int PW = $clog2(PROG_DEPTH);
   localparam int LW = $clog2(PROG_DEPTH + 1);
   localparam int TW = $clog2(TAPE_SIZE);
   localparam int SI = $clog2(NEST_DEPTH);
   localparam int SW = $clog2(NEST_DEPTH + 1);

   // Control state
   bfi_pkg::state_type state_ff, state_in;
   logic [LW-1:0]      len_ff, len_in;       // program length
   logic [LW-1:0]      pc_ff, pc_in;         // program counter
   logic [SW-1:0]      level_ff, level_in;   // bracket stack level
   logic [TW-1:0]      ptr_ff, ptr_in;       // tape pointer
   logic               run_ff, run_in;       // 0 loading, 1 running
   logic               err_ff, err_in;       // code error seen
   logic               wants_ff, wants_in;   // next command is a read
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload registers
   bfi_pkg::req_type   req_ff, req_in;
   bfi_pkg::rsp_type   res_ff, res_in;       // result under construction
   bfi_pkg::rsp_type   rsp_ff, rsp_in;       // output register
   logic [TW-1:0]      clr_ff, clr_in;       // tape sweep counter
   logic [PW-1:0]      at_ff, at_in;         // ']' position of a pair
   logic [PW-1:0]      other_ff, other_in;   // matching '[' position

   // Memories
   logic [3:0]    prog_mem  [PROG_DEPTH];
   logic [PW-1:0] jump_mem  [PROG_DEPTH];
   logic [PW-1:0] stack_mem [NEST_DEPTH];
   logic [7:0]    tape_mem  [TAPE_SIZE];

   logic [3:0]    prog_q;
   logic [PW-1:0] jump_q;
   logic [PW-1:0] stack_q;
   logic [7:0]    tape_q;

   logic          prog_we;
   logic [3:0]    prog_wd;
   logic          jump_we;
   logic [PW-1:0] jump_wa, jump_wd;
   logic          stack_we;
   logic          tape_we;
   logic [TW-1:0] tape_wa;
   logic [7:0]    tape_wd;

   logic [SW-1:0] level_dec;
   logic [SI-1:0] stack_ra;

   // Shared decode of the held request and the fetched command
   bfi_pkg::op_type load_op;
   bfi_pkg::op_type exec_op;
   logic            accept;
   logic            rsp_free;
   logic            finish_ok;
   logic            prog_full;
   logic            pc_in_range;
   logic            ptr_at_top;
   logic            ptr_at_zero;
   logic            exec_fault;
   logic            exec_jump;

   assign accept      = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign finish_ok   = !err_ff && (level_ff == '0);
   assign prog_full   = (len_ff == LW'(PROG_DEPTH));
   assign pc_in_range = (pc_ff < len_ff);
   assign ptr_at_top  = (ptr_ff == TW'(TAPE_SIZE - 1));
   assign ptr_at_zero = (ptr_ff == '0);
   assign load_op     = bfi_pkg::decode_op(req_ff.value);
   assign exec_op     = bfi_pkg::op_type'(prog_q);
   assign exec_fault  = ((exec_op == bfi_pkg::OP_RIGHT) && ptr_at_top) ||
                        ((exec_op == bfi_pkg::OP_LEFT) && ptr_at_zero);
   assign exec_jump   = ((exec_op == bfi_pkg::OP_OPEN) && (tape_q == 8'd0)) ||
                        ((exec_op == bfi_pkg::OP_CLOSE) && (tape_q != 8'd0));
   assign level_dec   = level_ff - 1'b1;
   assign stack_ra    = level_dec[SI-1:0];

   assign req_ready = (state_ff == bfi_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfi_pkg::S_IDLE: begin
            if (req_valid) begin
               unique case (req_data.action)
                  bfi_pkg::ACT_LOAD: state_in = bfi_pkg::S_LOAD;
                  bfi_pkg::ACT_FINISH: begin
                     state_in = (!run_ff && finish_ok) ? bfi_pkg::S_CLEAR
                                                       : bfi_pkg::S_DONE;
                  end
                  bfi_pkg::ACT_RUN: begin
                     state_in = (run_ff && pc_in_range) ? bfi_pkg::S_EXEC
                                                        : bfi_pkg::S_DONE;
                  end
                  default: state_in = bfi_pkg::S_DONE;
               endcase
            end
         end
         bfi_pkg::S_LOAD: begin
            if (req_ff.value == bfi_pkg::CH_NEWLINE) begin
               state_in = finish_ok ? bfi_pkg::S_CLEAR : bfi_pkg::S_DONE;
            end else if (!prog_full && (load_op == bfi_pkg::OP_CLOSE) &&
                         (level_ff != '0)) begin
               state_in = bfi_pkg::S_PAIR;
            end else begin
               state_in = bfi_pkg::S_DONE;
            end
         end
         bfi_pkg::S_PAIR:  state_in = bfi_pkg::S_DONE;
         bfi_pkg::S_CLEAR: begin
            if (clr_ff == TW'(TAPE_SIZE - 1)) begin
               state_in = bfi_pkg::S_WANT;
            end
         end
         bfi_pkg::S_EXEC: state_in = exec_fault ? bfi_pkg::S_DONE : bfi_pkg::S_WANT;
         bfi_pkg::S_WANT: state_in = bfi_pkg::S_DONE;
         bfi_pkg::S_DONE: begin
            if (rsp_free) begin
               state_in = bfi_pkg::S_IDLE;
            end
         end
         default: state_in = bfi_pkg::S_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // Datapath and memory controls
   // ------------------------------------------------------------------------
   always_comb begin
      len_in    = len_ff;
      pc_in     = pc_ff;
      level_in  = level_ff;
      ptr_in    = ptr_ff;
      run_in    = run_ff;
      err_in    = err_ff;
      wants_in  = wants_ff;
      req_in    = req_ff;
      res_in    = res_ff;
      clr_in    = clr_ff;
      at_in     = at_ff;
      other_in  = other_ff;
      prog_we   = 1'b0;
      prog_wd   = load_op;
      jump_we   = 1'b0;
      jump_wa   = len_ff[PW-1:0];
      jump_wd   = stack_q;
      stack_we  = 1'b0;
      tape_we   = 1'b0;
      tape_wa   = ptr_ff;
      tape_wd   = tape_q;

      unique case (state_ff)
         bfi_pkg::S_IDLE: begin
            if (accept) begin
               req_in          = req_data;
               res_in.kind     = bfi_pkg::KIND_NONE;
               res_in.out_byte = 8'd0;
               res_in.wants_input = wants_ff;
               unique case (req_data.action)
                  bfi_pkg::ACT_LOAD: begin
                     // A load during a run abandons it
                     if (run_ff) begin
                        len_in   = '0;
                        level_in = '0;
                        err_in   = 1'b0;
                        pc_in    = '0;
                        run_in   = 1'b0;
                        wants_in = 1'b0;
                     end
                  end
                  bfi_pkg::ACT_FINISH: begin
                     if (!run_ff) begin
                        if (finish_ok) begin
                           res_in.kind = bfi_pkg::KIND_ACCEPT;
                           run_in      = 1'b1;
                           ptr_in      = '0;
                           pc_in       = '0;
                           clr_in      = '0;
                        end else begin
                           res_in.kind = bfi_pkg::KIND_INVALID;
                           len_in      = '0;
                           level_in    = '0;
                           err_in      = 1'b0;
                           pc_in       = '0;
                        end
                     end
                  end
                  bfi_pkg::ACT_RUN: begin
                     if (run_ff && !pc_in_range) begin
                        res_in.kind        = bfi_pkg::KIND_END;
                        res_in.wants_input = 1'b0;
                        len_in   = '0;
                        level_in = '0;
                        err_in   = 1'b0;
                        pc_in    = '0;
                        run_in   = 1'b0;
                        wants_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end
         end

         bfi_pkg::S_LOAD: begin
            res_in.wants_input = 1'b0;
            if (req_ff.value == bfi_pkg::CH_NEWLINE) begin
               if (finish_ok) begin
                  res_in.kind = bfi_pkg::KIND_ACCEPT;
                  run_in      = 1'b1;
                  ptr_in      = '0;
                  pc_in       = '0;
                  clr_in      = '0;
               end else begin
                  res_in.kind = bfi_pkg::KIND_INVALID;
                  len_in      = '0;
                  level_in    = '0;
                  err_in      = 1'b0;
                  pc_in       = '0;
               end
            end else if (prog_full) begin
               err_in = 1'b1;
            end else begin
               prog_we = 1'b1;
               len_in  = len_ff + 1'b1;
               if (load_op == bfi_pkg::OP_OPEN) begin
                  if (level_ff == SW'(NEST_DEPTH)) begin
                     err_in = 1'b1;
                  end else begin
                     stack_we = 1'b1;
                     level_in = level_ff + 1'b1;
                  end
               end else if (load_op == bfi_pkg::OP_CLOSE) begin
                  if (level_ff == '0) begin
                     err_in = 1'b1;
                  end else begin
                     // ']' -> '[' now, '[' -> ']' in the next cycle
                     level_in = level_dec;
                     jump_we  = 1'b1;
                     jump_wa  = len_ff[PW-1:0];
                     jump_wd  = stack_q;
                     at_in    = len_ff[PW-1:0];
                     other_in = stack_q;
                  end
               end
            end
         end

         bfi_pkg::S_PAIR: begin
            jump_we = 1'b1;
            jump_wa = other_ff;
            jump_wd = at_ff;
         end

         bfi_pkg::S_CLEAR: begin
            tape_we = 1'b1;
            tape_wa = clr_ff;
            tape_wd = 8'd0;
            clr_in  = clr_ff + 1'b1;
         end

         bfi_pkg::S_EXEC: begin
            if (exec_fault) begin
               res_in.kind        = bfi_pkg::KIND_FAULT;
               res_in.wants_input = 1'b0;
               len_in   = '0;
               level_in = '0;
               err_in   = 1'b0;
               pc_in    = '0;
               run_in   = 1'b0;
               wants_in = 1'b0;
            end else begin
               pc_in = exec_jump ? (LW'(jump_q) + 1'b1) : (pc_ff + 1'b1);
               unique case (exec_op)
                  bfi_pkg::OP_RIGHT: ptr_in = ptr_ff + 1'b1;
                  bfi_pkg::OP_LEFT:  ptr_in = ptr_ff - 1'b1;
                  bfi_pkg::OP_INC: begin
                     tape_we = 1'b1;
                     tape_wd = tape_q + 8'd1;
                  end
                  bfi_pkg::OP_DEC: begin
                     tape_we = 1'b1;
                     tape_wd = tape_q - 8'd1;
                  end
                  bfi_pkg::OP_IN: begin
                     tape_we = 1'b1;
                     tape_wd = req_ff.value;
                  end
                  bfi_pkg::OP_OUT: begin
                     res_in.kind     = bfi_pkg::KIND_BYTE;
                     res_in.out_byte = tape_q;
                  end
                  default: ;
               endcase
            end
         end

         bfi_pkg::S_WANT: begin
            // prog_q now holds the command at the new counter
            wants_in = run_ff && pc_in_range &&
                       (bfi_pkg::op_type'(prog_q) == bfi_pkg::OP_IN);
            res_in.wants_input = wants_in;
         end

         bfi_pkg::S_DONE: ;

         default: ;
      endcase
   end

   // Output register: loaded from the result once the slot is free
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == bfi_pkg::S_DONE) && rsp_free) begin
         rsp_in       = res_ff;
         rsp_valid_in = 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfi_pkg::S_IDLE;
         len_ff       <= '0;
         pc_ff        <= '0;
         level_ff     <= '0;
         ptr_ff       <= '0;
         run_ff       <= 1'b0;
         err_ff       <= 1'b0;
         wants_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         pc_ff        <= pc_in;
         level_ff     <= level_in;
         ptr_ff       <= ptr_in;
         run_ff       <= run_in;
         err_ff       <= err_in;
         wants_ff     <= wants_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
      clr_ff   <= clr_in;
      at_ff    <= at_in;
      other_ff <= other_in;
   end

   // ------------------------------------------------------------------------
   // Memories, registered reads
   // ------------------------------------------------------------------------
   // Program store is read at the next counter so the command is ready in the
   // same cycle as the new counter value.
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[len_ff[PW-1:0]] <= prog_wd;
      end
      prog_q <= prog_mem[pc_in[PW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (jump_we) begin
         jump_mem[jump_wa] <= jump_wd;
      end
      jump_q <= jump_mem[pc_ff[PW-1:0]];
   end

   // Top of stack is read continuously at level - 1
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[level_ff[SI-1:0]] <= len_ff[PW-1:0];
      end
      stack_q <= stack_mem[stack_ra];
   end

   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_wa] <= tape_wd;
      end
      tape_q <= tape_mem[ptr_ff];
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   a_exec_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfi_pkg::S_EXEC) |-> (run_ff && (pc_ff < len_ff)))
      else $error("execute entered with counter outside the program");

   a_wants_only_running: assert property (@(posedge clock) disable iff (reset)
      !run_ff |-> !wants_ff)
      else $error("read request flagged while loading");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= SW'(NEST_DEPTH))
      else $error("bracket stack level beyond its depth");

   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      ptr_ff <= TW'(TAPE_SIZE - 1))
      else $error("tape pointer outside the tape");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("ready again directly after a request transaction");

endmodule
